>>> rtl/core/rdc_pkg.sv
// rdc_pkg: shared types, constants and helper functions of the radix digit converter
// no dependencies; imported by every module in rtl/core
package rdc_pkg;

   localparam int VALUE_W      = 31;
   localparam int BASE_W       = 5;
   localparam int CHAR_W       = 7;
   localparam int DIGIT_W      = 4;
   localparam int RESULT_LIMIT = 31;
   localparam int RADIX_MIN    = 2;
   localparam int RADIX_MAX    = 16;

   // the divider walks the value one byte-wide chunk per cycle
   localparam int CHUNK_W     = 8;
   localparam int N_CHUNKS    = 4;
   localparam int CHUNK_IDX_W = 2;
   localparam int WORK_W      = CHUNK_W * N_CHUNKS;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
   localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;

   // one classified request as it sits in the queue
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0]  radix;
   } item_type;

   typedef struct packed {
      logic [CHUNK_W-1:0] quo;
      logic [DIGIT_W-1:0] rem;
   } chunk_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } back_state_type;

   // long division of one chunk, msb first, carrying the running remainder
   function automatic chunk_res_type chunk_div(input logic [DIGIT_W-1:0] rem_in,
                                               input logic [CHUNK_W-1:0] bits,
                                               input logic [BASE_W-1:0]  radix);
      chunk_res_type      res;
      logic [BASE_W-1:0]  part;
      res.quo = '0;
      res.rem = rem_in;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         part = {res.rem, bits[i]};
         if (part >= radix) begin
            part       = part - radix;
            res.quo[i] = 1'b1;
         end
         res.rem = part[DIGIT_W-1:0];
      end
      return res;
   endfunction

   // highest chunk holding a set bit, zero for an all-zero word
   function automatic logic [CHUNK_IDX_W-1:0] lead_chunk(input logic [WORK_W-1:0] v);
      logic [CHUNK_IDX_W-1:0] idx;
      idx = '0;
      for (int c = 1; c < N_CHUNKS; c++) begin
         if (v[c*CHUNK_W +: CHUNK_W] != '0) begin
            idx = CHUNK_IDX_W'(c);
         end
      end
      return idx;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 4'd10) begin
         c = ASCII_ZERO + CHAR_W'(d);
      end else begin
         c = ASCII_A + CHAR_W'(d - 4'd10);
      end
      return c;
   endfunction

endpackage

>>> rtl/core/rdc_queue.sv
// rdc_queue: two-entry request queue between the intake and the conversion engine
// depends on rdc_pkg (item_type)
module rdc_queue
   import rdc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // pointers differ exactly when the queue holds one entry
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue fill count out of range");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue pop lost");

endmodule

>>> rtl/core/rdc_front.sv
// rdc_front: request intake; clamps the radix into 2..16 and hands requests to the queue
// depends on rdc_pkg (item_type, radix limits)
module rdc_front
   import rdc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [BASE_W-1:0]  req_base,
   output logic               q_push,
   output item_type           q_item,
   input  logic               q_full
);

   logic     slot_valid_ff, slot_valid_in;
   item_type slot_item_ff, slot_item_in;
   logic     accept;

   assign q_push   = slot_valid_ff && !q_full;
   assign req_full = slot_valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_item   = slot_item_ff;

   always_comb begin
      slot_item_in.value = req_value;
      if (req_base < BASE_W'(RADIX_MIN)) begin
         slot_item_in.radix = BASE_W'(RADIX_MIN);
      end else if (req_base > BASE_W'(RADIX_MAX)) begin
         slot_item_in.radix = BASE_W'(RADIX_MAX);
      end else begin
         slot_item_in.radix = req_base;
      end
      slot_valid_in = accept ? 1'b1 : (q_push ? 1'b0 : slot_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_item_ff <= slot_item_in;
      end
   end

endmodule

>>> rtl/core/rdc_back.sv
// rdc_back: conversion engine; chunked long division into the digit store, then
// msb-first character emission through a one-entry result register; depends on rdc_pkg
module rdc_back
   import rdc_pkg::*;
#(
   parameter int MAX_DIGITS = 32
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  item_type          q_item,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [CHAR_W-1:0] rsp_digit_char,
   output logic              rsp_last_digit
);

   localparam int AW    = $clog2(MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   back_state_type state_ff, state_in;

   logic [WORK_W-1:0]      val_ff, val_in;
   logic [BASE_W-1:0]      radix_ff, radix_in;
   logic [CHUNK_IDX_W-1:0] chunk_ff, chunk_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   issued_all_ff, issued_all_in;

   logic [DIGIT_W-1:0]     store_mem [MAX_DIGITS];
   logic [DIGIT_W-1:0]     rd_digit_ff;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   rd_last_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]      out_char_ff;
   logic                   out_last_ff;

   chunk_res_type          res;
   logic [4:0]             bit_base;
   logic [WORK_W-1:0]      quo_word;
   logic                   digit_done, div_finish;
   logic [CNT_W-1:0]       new_count, emit_count;
   logic                   mem_we, rd_en, out_load, pop_acc;

   // one chunk of long division per cycle
   assign bit_base = {chunk_ff, 3'b000};
   assign res      = chunk_div(rem_ff, val_ff[bit_base +: CHUNK_W], radix_ff);

   always_comb begin
      quo_word                       = val_ff;
      quo_word[bit_base +: CHUNK_W]  = res.quo;
   end

   assign digit_done = (state_ff == ST_DIVIDE) && (chunk_ff == '0);
   assign new_count  = count_ff + CNT_W'(1);
   assign div_finish = digit_done &&
                       ((quo_word == '0) || (count_ff == CNT_W'(MAX_DIGITS - 1)));
   assign emit_count = (8'(new_count) > 8'(RESULT_LIMIT)) ? CNT_W'(RESULT_LIMIT)
                                                          : new_count;
   assign pop_acc    = rsp_pop && out_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_finish) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (issued_all_ff && !rd_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      rd_en    = 1'b0;
      out_load = rd_valid_ff && (!out_valid_ff || pop_acc);
      unique case (state_ff)
         ST_IDLE:   q_pop  = !q_empty;
         ST_DIVIDE: mem_we = digit_done;
         ST_EMIT:   rd_en  = !issued_all_ff && (!rd_valid_ff || out_load);
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      val_in        = val_ff;
      radix_in      = radix_ff;
      chunk_in      = chunk_ff;
      rem_in        = rem_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      issued_all_in = issued_all_ff;
      if (q_pop) begin
         val_in   = WORK_W'(q_item.value);
         radix_in = q_item.radix;
         chunk_in = lead_chunk(WORK_W'(q_item.value));
         rem_in   = '0;
         count_in = '0;
      end else if (state_ff == ST_DIVIDE) begin
         val_in = quo_word;
         if (digit_done) begin
            count_in = new_count;
            chunk_in = lead_chunk(quo_word);
            rem_in   = '0;
            if (div_finish) begin
               idx_in        = emit_count - CNT_W'(1);
               issued_all_in = 1'b0;
            end
         end else begin
            chunk_in = chunk_ff - CHUNK_IDX_W'(1);
            rem_in   = res.rem;
         end
      end else if (rd_en) begin
         idx_in        = idx_ff - CNT_W'(1);
         issued_all_in = (idx_ff == '0);
      end
      rd_valid_in  = rd_en ? 1'b1 : (out_load ? 1'b0 : rd_valid_ff);
      out_valid_in = out_load ? 1'b1 : (pop_acc ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         issued_all_ff <= 1'b1;
         rd_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issued_all_ff <= issued_all_in;
         rd_valid_ff   <= rd_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      radix_ff <= radix_in;
      chunk_ff <= chunk_in;
      rem_ff   <= rem_in;
      idx_ff   <= idx_in;
      if (out_load) begin
         out_char_ff <= digit_to_char(rd_digit_ff);
         out_last_ff <= rd_last_ff;
      end
   end

   // digit store, least significant digit at entry zero
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[count_ff[AW-1:0]] <= res.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_digit_ff <= store_mem[idx_ff[AW-1:0]];
         rd_last_ff  <= (idx_ff == '0);
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last_digit = out_last_ff;

   a_remainder_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < radix_ff)
      else $error("running remainder not below radix");

   a_radix_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> (radix_ff >= BASE_W'(RADIX_MIN)) &&
                                (radix_ff <= BASE_W'(RADIX_MAX)))
      else $error("radix outside 2..16 in divider");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count beyond store depth");

   a_read_in_emit: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> state_ff == ST_EMIT)
      else $error("store read data pending outside emission");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(out_char_ff))
      else $error("waiting result changed before it was taken");

endmodule

>>> rtl/core/radix_digit_converter.sv
// radix_digit_converter: top level of the integer to radix string converter
// depends on rdc_pkg, rdc_front, rdc_queue and rdc_back
//
// usage
//   request channel: drive req_value (0..2^31-1) and req_base, raise req_push;
//   the request is taken at a clock edge where req_push is high and req_full low.
//   bases 0 and 1 convert as radix 2, bases 17 to 31 as radix 16
//   result channel: one character per digit, most significant first, in
//   upper-case ascii 0-9A-F; rsp_last_digit marks the final character.
//   a character is shown while rsp_empty is low and taken when rsp_pop is high.
//   a zero value gives the single character '0'
// flow
//   a request passes through the intake slot and the queue before the engine loads it
//   each digit is found by walking the current quotient from its leading nonzero byte
//   down to byte zero, since the shared divider walks one byte per cycle
//   emission then runs at one character per cycle while the receiver takes each
//   character in turn, behind a registered read of the digit store
// reset and stalls
//   synchronous reset empties the intake slot, queue and result register; the
//   digit store keeps no reset value and needs none
//   a stalled receiver holds the engine in emission; up to three further
//   requests wait in the intake slot and queue before req_full rises
module radix_digit_converter
   import rdc_pkg::*;
#(
   parameter int MAX_DIGITS = 32
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [BASE_W-1:0]  req_base,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [CHAR_W-1:0]  rsp_digit_char,
   output logic               rsp_last_digit
);

   // intake to queue
   logic     fq_push;
   item_type fq_item;
   logic     fq_full;

   // queue to engine
   logic     qb_pop;
   item_type qb_item;
   logic     qb_empty;

   // intake classifies the request (radix clamp) and holds it for the queue
   rdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .req_base  (req_base),
      .q_push    (fq_push),
      .q_item    (fq_item),
      .q_full    (fq_full)
   );

   // short queue decouples intake from the conversion engine
   rdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_item (fq_item),
      .full      (fq_full),
      .pop       (qb_pop),
      .pop_item  (qb_item),
      .empty     (qb_empty)
   );

   // engine divides into the digit store, then drives the result register
   rdc_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (qb_empty),
      .q_item         (qb_item),
      .q_pop          (qb_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule
